// ===== sv/pwlcm_chaotic_step_top_defines.svh =====
`ifndef PWLCM_CHAOTIC_STEP_TOP_DEFINES_SVH
`define PWLCM_CHAOTIC_STEP_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PWLCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence checked at the clock after the antecedent
`define PWLCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pwlcm_pkg.sv =====
package pwlcm_pkg;

  localparam logic REG_MAP_PARAMETER = 1'b0;
  localparam logic REG_SEED_VALUE    = 1'b1;

  localparam logic [31:0] PAR_RESET  = 32'd15176;
  localparam logic [31:0] SEED_RESET = 32'd8090;

  typedef struct packed {
    logic start;
    logic step;
    logic state_wr;
    logic out_load;
    logic out_src_state;
  } pwlcm_cmd_t;

  typedef struct packed {
    logic div_last;
  } pwlcm_status_t;

endpackage

// ===== sv/pwlcm_dp.sv =====
`include "pwlcm_chaotic_step_top_defines.svh"

module pwlcm_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [FRAC_BITS:0]       cfg_wdata,
  input  logic                     in_restart,
  input  pwlcm_pkg::pwlcm_cmd_t    cmd,
  output pwlcm_pkg::pwlcm_status_t status,
  output logic [FRAC_BITS:0]       out_next_value
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0]   ONE_VAL  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS-1:0] HALF_VAL = {1'b1, {(FRAC_BITS-1){1'b0}}};

  logic [FRAC_BITS-2:0] par_r;
  logic [FRAC_BITS:0]   seed_r;
  logic [FRAC_BITS:0]   state_r;
  logic [FRAC_BITS:0]   rem_r, rem_nxt;
  logic [FRAC_BITS-1:0] dvs_r;
  logic [FRAC_BITS:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [FRAC_BITS:0]   out_r;

  logic [FRAC_BITS:0]   src_val, sat_val, fold_full;
  logic [FRAC_BITS-1:0] fold_val, par_ext, num_a, den_d;
  logic                 below_par;
  logic [FRAC_BITS:0]   dvs_ext, rem_diff, rem_keep;
  logic                 rem_ge;

  // fold and branch select
  always_comb begin
    src_val   = in_restart ? seed_r : state_r;
    sat_val   = (src_val > ONE_VAL) ? ONE_VAL : src_val;
    fold_full = (sat_val >= {1'b0, HALF_VAL}) ? (ONE_VAL - sat_val) : sat_val;
    fold_val  = fold_full[FRAC_BITS-1:0];
    par_ext   = {1'b0, par_r};
    below_par = fold_val < par_ext;
    num_a     = below_par ? fold_val : (fold_val - par_ext);
    den_d     = below_par ? par_ext : (HALF_VAL - par_ext);
  end

  // restoring division step
  always_comb begin
    dvs_ext  = {1'b0, dvs_r};
    rem_ge   = rem_r >= dvs_ext;
    rem_diff = rem_r - dvs_ext;
    rem_keep = rem_ge ? rem_diff : rem_r;
    rem_nxt  = {rem_keep[FRAC_BITS-1:0], 1'b0};
    quo_nxt  = {quo_r[FRAC_BITS-1:0], rem_ge};
  end

  assign status.div_last = (cnt_r == '0);
  assign out_next_value  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r   <= pwlcm_pkg::PAR_RESET[FRAC_BITS-2:0];
      seed_r  <= pwlcm_pkg::SEED_RESET[FRAC_BITS:0];
      state_r <= pwlcm_pkg::SEED_RESET[FRAC_BITS:0];
    end else begin
      if (cfg_we && (cfg_index == pwlcm_pkg::REG_MAP_PARAMETER)) begin
        par_r <= cfg_wdata[FRAC_BITS-2:0];
      end
      if (cfg_we && (cfg_index == pwlcm_pkg::REG_SEED_VALUE)) begin
        seed_r <= cfg_wdata;
      end
      if (cmd.state_wr) begin
        state_r <= quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= {1'b0, num_a};
      dvs_r <= den_d;
      quo_r <= '0;
      cnt_r <= CNT_W'(FRAC_BITS);
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_r <= cmd.out_src_state ? state_r : quo_nxt;
    end
  end

  `PWLCM_ASSERT_IMP(a_rem_bound, cmd.step, rem_r < (dvs_ext << 1), "remainder out of range")
  `PWLCM_ASSERT_NXT(a_state_range, cmd.state_wr, state_r <= ONE_VAL, "state above one")
  `PWLCM_ASSERT_IMP(a_div_nonzero, cmd.step, dvs_r != '0, "zero divisor")

endmodule

// ===== sv/pwlcm_ctrl.sv =====
`include "pwlcm_chaotic_step_top_defines.svh"

module pwlcm_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  pwlcm_pkg::pwlcm_status_t status,
  output pwlcm_pkg::pwlcm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          cmd.state_wr = 1'b1;
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.out_load      = 1'b1;
          cmd.out_src_state = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PWLCM_ASSERT_NXT(a_accept_div, in_valid && !in_stall, state_r == S_DIV, "accept did not start division")
  `PWLCM_ASSERT_IMP(a_valid_src, $rose(out_valid_r), $past(cmd.out_load), "result without load")
  `PWLCM_ASSERT_NXT(a_hold_full, (state_r == S_DIV) && status.div_last && !out_free, state_r == S_HOLD && out_valid_r, "finished result lost")

endmodule

// ===== sv/pwlcm_chaotic_step_top.sv =====
// Piecewise linear chaotic map stepper in unsigned fixed point with FRAC_BITS fraction
// bits. Each input transaction advances the trajectory by one step (restart first takes the
// value in the seed register) and returns one result transaction with the new value. On
// acceptance the state is folded and the division is set up, then a radix-2 restoring
// divider produces one quotient bit per cycle until it has FRAC_BITS + 1 of them. The
// result sits in an output register, so the next input transaction is taken while it
// waits; if the output is still stalled when the following result is done, the input
// stalls until it drains. Configuration writes take effect at the next clock edge; the
// user must make them only while the block is idle, as the block does not enforce it.
module pwlcm_chaotic_step_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [FRAC_BITS:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAC_BITS:0] out_next_value
);

  pwlcm_pkg::pwlcm_cmd_t    cmd;
  pwlcm_pkg::pwlcm_status_t status;

  pwlcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pwlcm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_restart     (in_restart),
    .cmd            (cmd),
    .status         (status),
    .out_next_value (out_next_value)
  );

endmodule

// ===== sim/pwlcm_step_checker.sv =====
`timescale 1ns / 1ps
module pwlcm_step_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [FRAC_BITS:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_restart,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [FRAC_BITS:0] out_next_value,
  output int                 mismatch_count,
  output int                 traj_pending
);

  localparam logic [63:0] ONE_Q  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_Q = 64'd1 << (FRAC_BITS - 1);

  logic [FRAC_BITS-2:0] map_par;
  logic [FRAC_BITS:0]   seed_reg;
  logic [FRAC_BITS:0]   traj_value;
  logic [FRAC_BITS:0]   traj_expected_q[$];
  int                   errs;

  // fold into the lower half, then divide on whichever side of p it lands
  function automatic logic [FRAC_BITS:0] pwlcm_fold_divide(
    input logic [FRAC_BITS:0]   v,
    input logic [FRAC_BITS-2:0] p
  );
    logic [63:0] f;
    logic [63:0] q;
    f = (64'(v) > ONE_Q) ? ONE_Q : 64'(v);
    if (f >= HALF_Q) begin
      f = ONE_Q - f;
    end
    if (f < 64'(p)) begin
      q = (f << FRAC_BITS) / 64'(p);
    end else begin
      q = ((f - 64'(p)) << FRAC_BITS) / (HALF_Q - 64'(p));
    end
    return q[FRAC_BITS:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [FRAC_BITS:0] want;
    if (!rst_n) begin
      map_par    = pwlcm_pkg::PAR_RESET[FRAC_BITS-2:0];
      seed_reg   = pwlcm_pkg::SEED_RESET[FRAC_BITS:0];
      traj_value = pwlcm_pkg::SEED_RESET[FRAC_BITS:0];
      traj_expected_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pwlcm_pkg::REG_MAP_PARAMETER) begin
          map_par = cfg_wdata[FRAC_BITS-2:0];
        end else begin
          seed_reg = cfg_wdata;
        end
      end
      if (in_valid && !in_stall) begin
        if (in_restart) begin
          traj_value = seed_reg;
        end
        traj_value = pwlcm_fold_divide(traj_value, map_par);
        traj_expected_q.push_back(traj_value);
      end
      if (out_valid && !out_stall) begin
        if (traj_expected_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result transaction, next_value=%0d",
                   $time, out_next_value);
        end else begin
          want = traj_expected_q.pop_front();
          if (out_next_value !== want) begin
            errs++;
            $display("%0t: next_value mismatch, expected %0d, actual %0d",
                     $time, want, out_next_value);
          end
        end
      end
    end
    mismatch_count <= errs;
    traj_pending   <= traj_expected_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int FRAC_BITS = 16;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic               cfg_index  = pwlcm_pkg::REG_MAP_PARAMETER;
  logic [FRAC_BITS:0] cfg_wdata  = '0;
  logic               in_valid   = 1'b0;
  logic               in_restart = 1'b0;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [FRAC_BITS:0] out_next_value;
  int                 mismatch_count;
  int                 traj_pending;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;

  pwlcm_chaotic_step_top #(.FRAC_BITS(FRAC_BITS)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_value (out_next_value)
  );

  pwlcm_step_checker #(.FRAC_BITS(FRAC_BITS)) traj_watch (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_value (out_next_value),
    .mismatch_count (mismatch_count),
    .traj_pending   (traj_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic step_map(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_trajectory();
    in_valid <= 1'b0;
    do @(posedge clk); while (traj_pending != 0);
  endtask

  task automatic set_map_regs(input logic [FRAC_BITS-2:0] par,
                              input logic [FRAC_BITS:0] seed);
    cfg_we    <= 1'b1;
    cfg_index <= pwlcm_pkg::REG_MAP_PARAMETER;
    cfg_wdata <= {2'b00, par};
    @(posedge clk);
    cfg_index <= pwlcm_pkg::REG_SEED_VALUE;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic walk_from_seed(input logic [FRAC_BITS-2:0] par,
                                input logic [FRAC_BITS:0] seed, input int steps);
    drain_trajectory();
    set_map_regs(par, seed);
    step_map(1'b1);
    repeat (steps - 1) step_map(1'b0);
  endtask

  initial begin : stimulus
    logic [FRAC_BITS-2:0] par;
    logic [FRAC_BITS:0]   seed;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    step_map(1'b0);
    step_map(1'b0);
    step_map(1'b1);
    step_map(1'b0);

    // parameter zero, fixed point zero, one, above one, half, extremes of p
    walk_from_seed(15'd0, 17'd20000, 3);
    walk_from_seed(15'd0, 17'd0, 2);
    walk_from_seed(15'd15176, 17'd65536, 2);
    walk_from_seed(15'd15176, 17'd131071, 2);
    walk_from_seed(15'd32767, 17'd32768, 3);
    walk_from_seed(15'd1, 17'd1, 3);
    walk_from_seed(15'd32767, 17'd32767, 3);
    walk_from_seed(15'd1, 17'd65535, 3);

    for (int ph = 0; ph < 12; ph++) begin
      drain_trajectory();
      case (ph % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 58;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 58;
        end
        default: begin
          send_idle_pct  <= 20;
          recv_stall_pct <= 20;
        end
      endcase
      if (ph == 0) begin
        par = 15'd1;
      end else if (ph == 1) begin
        par = 15'd32767;
      end else begin
        par = 15'($urandom_range(32767));
      end
      if (ph % 3 == 2) begin
        seed = 17'($urandom_range(131071));
      end else begin
        seed = 17'($urandom_range(65536));
      end
      set_map_regs(par, seed);
      step_map(1'b1);
      repeat (74) step_map($urandom_range(15) == 0);
    end

    drain_trajectory();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && traj_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
